// ===== rtl/core/lkvc_pkg.sv =====
package lkvc_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int CAP_W       = 5;

   localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(MAX_ENTRIES);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_PUT = 1'b1
   } req_op_type;

   // one slot of the store: key, value and recency rank (0 = most recent)
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] rank;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // capacity zero acts as one, anything above the store size saturates
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      if (cap == '0) begin
         return CNT_W'(1);
      end else if (cap > CAP_W'(MAX_ENTRIES)) begin
         return CNT_W'(MAX_ENTRIES);
      end else begin
         return CNT_W'(cap);
      end
   endfunction

endpackage

// ===== rtl/core/lkvc_if.sv =====
interface lkvc_req_if import lkvc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic signed [KEY_W-1:0] key;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, req_type, key, value, input ready);
   modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] read_value;
   logic                    evicted;

   modport source (output valid, hit, read_value, evicted, input ready);
   modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

interface lkvc_csr_if import lkvc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

// ===== rtl/core/lkvc_ram.sv =====
module lkvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement, up to
// 16 entries. Each request word is a get or a put of a signed 32-bit key; each
// gives exactly one response word: hit, the value read (the stored value on a get
// hit, -1 on a get miss, 0 on every put) and an evicted flag for a put miss that
// replaced the least recent entry. Keys, values and recency ranks live in one
// 16-deep RAM with a registered read. A request first sweeps the n occupied
// entries to find the key and the oldest entry, then, unless it is a get miss,
// sweeps them again to age the ranks and write the slot back, covering the new
// slot as well when a put appends. The RAM port carries one entry per cycle
// during both sweeps.
// One request is worked on at a time; the next is taken while a finished
// response still waits in the output register. The capacity register (reset 16,
// zero acts as one, above 16 acts as 16) may only be written while no request is
// in flight. Lowering it below the fill level evicts nothing at once: later put
// misses replace the least recent entry and the fill level stays.
module lru_key_value_cache import lkvc_pkg::*; (
   input logic         clock,
   input logic         reset,
   lkvc_csr_if.sink    csr_if,
   lkvc_req_if.sink    req_if,
   lkvc_rsp_if.source  rsp_if
);

   // control
   state_type        state_ff, state_in;
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] occ_ff, occ_in;        // occupied slots are 0..occ-1
   logic [CNT_W-1:0] cnt_ff, cnt_in;        // sweep read address counter
   logic [CNT_W-1:0] lim_ff, lim_in;        // entries covered by this sweep
   logic             pend_ff, pend_in;      // RAM read data arrives this cycle
   logic [IDX_W-1:0] pidx_ff, pidx_in;      // address of that read data

   // request word held for the whole operation
   logic             put_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;

   // scan results
   logic             found_ff, found_in;
   logic [IDX_W-1:0] slot_ff, slot_in;      // slot to promote
   logic [IDX_W-1:0] bound_ff, bound_in;    // ranks below this age by one
   logic [VAL_W-1:0] rdval_ff, rdval_in;
   logic [IDX_W-1:0] old_ff, old_in;        // least recent slot so far
   logic [IDX_W-1:0] old_rank_ff, old_rank_in;

   // response word waiting for the output register
   logic             res_hit_ff, res_hit_in;
   logic [VAL_W-1:0] res_val_ff, res_val_in;
   logic             res_ev_ff, res_ev_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_val_ff;
   logic             rsp_ev_ff;

   // RAM port
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          wr_entry;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;

   logic req_fire;
   logic sweep_done;
   logic key_hit;
   logic is_older;

   lkvc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   assign req_fire   = req_if.valid & req_if.ready;
   assign sweep_done = (cnt_ff == lim_ff) && !pend_ff;

   // first match wins; ties on rank go to the higher slot, as a >= scan gives
   assign key_hit  = pend_ff && !found_ff && (rd_entry.key == key_ff);
   assign is_older = (pidx_ff == '0) || (rd_entry.rank >= old_rank_ff);

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sweep_done) begin
               // a get miss changes nothing in the store
               if (!put_ff && !found_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (sweep_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // datapath and RAM control
   // ------------------------------------------------------------------
   always_comb begin
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      bound_in     = bound_ff;
      rdval_in     = rdval_ff;
      old_in       = old_ff;
      old_rank_in  = old_rank_ff;
      res_hit_in   = res_hit_ff;
      res_val_in   = res_val_ff;
      res_ev_in    = res_ev_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cnt_ff[IDX_W-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pidx_ff;
      wr_entry     = rd_entry;

      // both sweeps issue one read per cycle until the limit
      if ((state_ff == ST_SCAN || state_ff == ST_UPDATE) && (cnt_ff < lim_ff)) begin
         ram_rd_en = 1'b1;
         cnt_in    = cnt_ff + CNT_W'(1);
         pend_in   = 1'b1;
         pidx_in   = cnt_ff[IDX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               lim_in      = occ_ff;
               cnt_in      = '0;
               found_in    = 1'b0;
               old_in      = '0;
               old_rank_in = '0;
            end
         end
         ST_SCAN: begin
            if (key_hit) begin
               found_in = 1'b1;
               slot_in  = pidx_ff;
               bound_in = rd_entry.rank;
               rdval_in = rd_entry.value;
            end
            if (pend_ff && is_older) begin
               old_in      = pidx_ff;
               old_rank_in = rd_entry.rank;
            end
            if (sweep_done) begin
               cnt_in     = '0;
               lim_in     = occ_ff;
               res_hit_in = 1'b0;
               res_val_in = '0;
               res_ev_in  = 1'b0;
               if (found_ff) begin
                  res_hit_in = 1'b1;
                  res_val_in = put_ff ? '0 : rdval_ff;
               end else if (!put_ff) begin
                  res_val_in = MISS_VALUE;
               end else if (occ_ff >= eff_cap(cap_ff)) begin
                  // full: reuse the least recent slot
                  slot_in   = old_ff;
                  bound_in  = old_rank_ff;
                  res_ev_in = 1'b1;
               end else begin
                  // append at the end; everything already present ages
                  slot_in  = occ_ff[IDX_W-1:0];
                  bound_in = occ_ff[IDX_W-1:0];
                  occ_in   = occ_ff + CNT_W'(1);
                  lim_in   = occ_ff + CNT_W'(1);
               end
            end
         end
         ST_UPDATE: begin
            // read-modify-write one entry per cycle, one address behind the reads
            if (pend_ff) begin
               ram_wr_en = 1'b1;
               if (pidx_ff == slot_ff) begin
                  wr_entry.key   = key_ff;
                  wr_entry.value = put_ff ? val_ff : rd_entry.value;
                  wr_entry.rank  = '0;
               end else if (rd_entry.rank < bound_ff) begin
                  wr_entry.rank = rd_entry.rank + IDX_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            cap_ff <= csr_if.capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      lim_ff      <= lim_in;
      pidx_ff     <= pidx_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      bound_ff    <= bound_in;
      rdval_ff    <= rdval_in;
      old_ff      <= old_in;
      old_rank_ff <= old_rank_in;
      res_hit_ff  <= res_hit_in;
      res_val_ff  <= res_val_in;
      res_ev_ff   <= res_ev_in;
      if (req_fire) begin
         put_ff <= (req_if.req_type == REQ_PUT);
         key_ff <= req_if.key;
         val_ff <= req_if.value;
      end
      if (rsp_load) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_val_ff <= res_val_ff;
         rsp_ev_ff  <= res_ev_ff;
      end
   end

   // ports
   assign csr_if.ready      = 1'b1;
   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.hit        = rsp_hit_ff;
   assign rsp_if.read_value = rsp_val_ff;
   assign rsp_if.evicted    = rsp_ev_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(MAX_ENTRIES))
      else $error("fill level beyond store size");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (occ_ff != $past(occ_ff))) |-> (occ_ff == $past(occ_ff) + CNT_W'(1)))
      else $error("fill level changed by other than one insert");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |-> !ram_wr_en)
      else $error("store written outside the update sweep");

   a_slot_covered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (CNT_W'(slot_ff) < lim_ff))
      else $error("promoted slot outside the update sweep");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response word loaded outside finish");

endmodule
